/* sv/sacl_pkg.sv */
// Shared types, constants and helper functions of the LRU cache tracker.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

  // Geometry of the tag store.
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W   = $clog2(MAX_WAYS + 1);
  localparam int LEAVES   = 1 << WAY_W;
  localparam int HALF     = LEAVES / 2;
  localparam int TREE_STEPS = WAY_W - 1;
  localparam int LVL_W    = WAY_W;
  localparam int TAG_W    = ADDR_WIDTH;
  localparam int STAMP_W  = 64;
  localparam int CNT_W    = 32;

  // Field widths fixed by the port list.
  localparam int CMD_W       = 2;
  localparam int ADDRESS_W   = 64;
  localparam int OUTCOME_W   = 2;
  localparam int SBITS_W     = 3;
  localparam int OFFS_W      = 5;
  localparam int WCFG_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Access commands.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  // Access outcomes.
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  // Configuration values after reset.
  localparam logic [SBITS_W-1:0] RST_SET_BITS    = 3'd0;
  localparam logic [OFFS_W-1:0]  RST_OFFSET_BITS = 5'd4;
  localparam logic [WCFG_W-1:0]  RST_WAYS        = 4'd1;

  // A decoded access as it waits between the front and the back.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SET_W-1:0]  set;
    logic [TAG_W-1:0]  tag;
    logic [WAYS_W-1:0] ways;
  } acc_item_t;

  // One candidate of the LRU search.
  typedef struct packed {
    logic               en;
    logic [WAY_W-1:0]   way;
    logic [STAMP_W-1:0] stamp;
  } lru_cand_t;

  // Keeps the lower way unless the upper one is enabled and either strictly older or the lower one is disabled.
  function automatic lru_cand_t pick_older(input lru_cand_t lo, input lru_cand_t hi);
    lru_cand_t r;
    if (!hi.en || (lo.en && (lo.stamp <= hi.stamp))) begin
      r = lo;
    end else begin
      r = hi;
    end
    return r;
  endfunction

  // Index of the lowest set bit.
  function automatic logic [WAY_W-1:0] first_one(input logic [MAX_WAYS-1:0] vec);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (vec[w]) begin
        idx = WAY_W'(w);
      end
    end
    return idx;
  endfunction

  // Adds a small increment and holds at all ones.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + {{(CNT_W - 1){1'b0}}, inc};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/sacl_front.sv */
// Front end: configuration registers and decoding of an access into set and tag.
`timescale 1ns / 1ps
`default_nettype none

module sacl_front (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire  [sacl_pkg::CMD_W-1:0]         command,
  input  wire  [sacl_pkg::ADDRESS_W-1:0]     address,
  output sacl_pkg::acc_item_t                item
);

  logic [sacl_pkg::SBITS_W-1:0] set_bits;
  logic [sacl_pkg::OFFS_W-1:0]  offset_bits;
  logic [sacl_pkg::WCFG_W-1:0]  ways_cfg;

  logic [sacl_pkg::SBITS_W-1:0]  sbits_eff;
  logic [sacl_pkg::SET_W-1:0]    set_mask;
  logic [sacl_pkg::TAG_W-1:0]    addr_m;
  logic [sacl_pkg::TAG_W-1:0]    shifted;
  logic [sacl_pkg::WAYS_W-1:0]   ways_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= sacl_pkg::RST_SET_BITS;
      offset_bits <= sacl_pkg::RST_OFFSET_BITS;
      ways_cfg    <= sacl_pkg::RST_WAYS;
    end else if (cfg_valid) begin
      case (cfg_index)
        sacl_pkg::CFG_SET_BITS:    set_bits    <= cfg_data[sacl_pkg::SBITS_W-1:0];
        sacl_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data[sacl_pkg::OFFS_W-1:0];
        sacl_pkg::CFG_WAYS:        ways_cfg    <= cfg_data[sacl_pkg::WCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(set_bits) > sacl_pkg::MAX_SET_BITS) begin
      sbits_eff = sacl_pkg::SBITS_W'(sacl_pkg::MAX_SET_BITS);
    end else begin
      sbits_eff = set_bits;
    end

    if (ways_cfg == '0) begin
      ways_eff = sacl_pkg::WAYS_W'(1);
    end else if (int'(ways_cfg) > sacl_pkg::MAX_WAYS) begin
      ways_eff = sacl_pkg::WAYS_W'(sacl_pkg::MAX_WAYS);
    end else begin
      ways_eff = sacl_pkg::WAYS_W'(ways_cfg);
    end

    addr_m   = sacl_pkg::TAG_W'(address[sacl_pkg::ADDR_WIDTH-1:0]);
    shifted  = addr_m >> offset_bits;
    set_mask = ~({sacl_pkg::SET_W{1'b1}} << sbits_eff);

    item.cmd  = command;
    item.set  = shifted[sacl_pkg::SET_W-1:0] & set_mask;
    item.tag  = shifted >> sbits_eff;
    item.ways = ways_eff;
  end

endmodule

`default_nettype wire

/* sv/sacl_queue.sv */
// Two-entry queue of decoded accesses between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module sacl_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  sacl_pkg::acc_item_t  push_item,
  input  wire                  pop,
  output sacl_pkg::acc_item_t  head,
  output logic                 not_empty,
  output logic                 full
);

  sacl_pkg::acc_item_t slots [sacl_pkg::QUEUE_DEPTH];
  logic [sacl_pkg::QPTR_W-1:0] wr_ptr;
  logic [sacl_pkg::QPTR_W-1:0] rd_ptr;
  logic [sacl_pkg::QCNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == sacl_pkg::QCNT_W'(sacl_pkg::QUEUE_DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/sacl_back.sv */
// Back end: set row memory, hit and LRU search, line update and running totals.
`timescale 1ns / 1ps
`default_nettype none

module sacl_back (
  input  wire                                clk,
  input  wire                                rst,
  input  sacl_pkg::acc_item_t                head,
  input  wire                                head_valid,
  output logic                               pop,
  output logic                               result_valid,
  output logic [sacl_pkg::OUTCOME_W-1:0]     outcome,
  output logic                               extra_hit,
  output logic [sacl_pkg::CNT_W-1:0]         hit_total,
  output logic [sacl_pkg::CNT_W-1:0]         miss_total,
  output logic [sacl_pkg::CNT_W-1:0]         eviction_total
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_TREE = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Set rows: valid bits, tags and stamps of all ways, read and written whole.
  logic [sacl_pkg::MAX_WAYS-1:0]                           mem_valid [sacl_pkg::NUM_SETS];
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0]      mem_tag   [sacl_pkg::NUM_SETS];
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0]    mem_stamp [sacl_pkg::NUM_SETS];
  logic [sacl_pkg::NUM_SETS-1:0]                           row_written;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [sacl_pkg::LVL_W-1:0]    lvl;

  sacl_pkg::acc_item_t                                  item;
  logic                                                 rd_ok;
  logic [sacl_pkg::MAX_WAYS-1:0]                        rd_valid;
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0]   rd_tag;
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0] rd_stamp;

  logic [sacl_pkg::MAX_WAYS-1:0] line_v;
  logic [sacl_pkg::MAX_WAYS-1:0] hit_now;
  logic [sacl_pkg::MAX_WAYS-1:0] empty_now;
  logic [sacl_pkg::MAX_WAYS-1:0] hit_vec;
  logic [sacl_pkg::MAX_WAYS-1:0] empty_vec;
  sacl_pkg::lru_cand_t           leaf [sacl_pkg::LEAVES];
  sacl_pkg::lru_cand_t           cand [sacl_pkg::HALF];

  logic [sacl_pkg::STAMP_W-1:0]  acc_cnt;
  logic [sacl_pkg::STAMP_W-1:0]  acc_cnt_new;
  logic [sacl_pkg::CNT_W-1:0]    hit_cnt;
  logic [sacl_pkg::CNT_W-1:0]    miss_count;
  logic [sacl_pkg::CNT_W-1:0]    evict_cnt;

  logic                           cmd_ok;
  logic                           hit_any;
  logic                           empty_any;
  logic [sacl_pkg::WAY_W-1:0]     victim;
  logic [sacl_pkg::OUTCOME_W-1:0] fin_outcome;
  logic [1:0]                     hit_inc;
  logic                           wr_en;
  logic [sacl_pkg::MAX_WAYS-1:0]                        new_valid;
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0]   new_tag;
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0] new_stamp;

  assign pop = (state == ST_IDLE) && head_valid;

  // A row never written since reset reads as an empty set with zero stamps.
  always_comb begin
    for (int w = 0; w < sacl_pkg::LEAVES; w++) begin
      leaf[w] = '0;
    end
    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      line_v[w]     = rd_ok && rd_valid[w];
      leaf[w].en    = (sacl_pkg::WAYS_W'(w) < item.ways);
      leaf[w].way   = sacl_pkg::WAY_W'(w);
      leaf[w].stamp = rd_ok ? rd_stamp[w] : '0;
      hit_now[w]    = leaf[w].en && line_v[w] && (rd_tag[w] == item.tag);
      empty_now[w]  = leaf[w].en && !line_v[w];
    end
  end

  always_comb begin
    acc_cnt_new = acc_cnt + 1'b1;
    cmd_ok      = (item.cmd == sacl_pkg::CMD_LOAD) || (item.cmd == sacl_pkg::CMD_STORE) ||
                  (item.cmd == sacl_pkg::CMD_MODIFY);
    hit_any     = |hit_vec;
    empty_any   = |empty_vec;
    if (hit_any) begin
      victim      = sacl_pkg::first_one(hit_vec);
      fin_outcome = sacl_pkg::OUT_HIT;
    end else if (empty_any) begin
      victim      = sacl_pkg::first_one(empty_vec);
      fin_outcome = sacl_pkg::OUT_FILL;
    end else begin
      victim      = cand[0].way;
      fin_outcome = sacl_pkg::OUT_EVICT;
    end
    if (!cmd_ok) begin
      fin_outcome = sacl_pkg::OUT_HIT;
    end
    hit_inc = {1'b0, cmd_ok && hit_any} + {1'b0, item.cmd == sacl_pkg::CMD_MODIFY};

    new_valid = line_v;
    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      new_tag[w]   = rd_tag[w];
      new_stamp[w] = rd_ok ? rd_stamp[w] : '0;
    end
    new_valid[victim] = 1'b1;
    new_tag[victim]   = hit_any ? rd_tag[victim] : item.tag;
    new_stamp[victim] = acc_cnt_new;

    wr_en = (state == ST_FIN) && cmd_ok;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (head_valid) state_next = ST_LOOK;
      ST_LOOK: state_next = (sacl_pkg::TREE_STEPS > 0) ? ST_TREE : ST_FIN;
      ST_TREE: if (lvl == sacl_pkg::LVL_W'(sacl_pkg::TREE_STEPS - 1)) state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Row memory and search registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      item     <= head;
      rd_ok    <= row_written[head.set];
      rd_valid <= mem_valid[head.set];
      rd_tag   <= mem_tag[head.set];
      rd_stamp <= mem_stamp[head.set];
    end
    if (wr_en) begin
      mem_valid[item.set] <= new_valid;
      mem_tag[item.set]   <= new_tag;
      mem_stamp[item.set] <= new_stamp;
    end
    if (state == ST_LOOK) begin
      hit_vec   <= hit_now;
      empty_vec <= empty_now;
      for (int i = 0; i < sacl_pkg::HALF; i++) begin
        cand[i] <= sacl_pkg::pick_older(leaf[2 * i], leaf[2 * i + 1]);
      end
    end else if (state == ST_TREE) begin
      for (int i = 0; i < sacl_pkg::HALF / 2; i++) begin
        cand[i] <= sacl_pkg::pick_older(cand[2 * i], cand[2 * i + 1]);
      end
      for (int i = sacl_pkg::HALF / 2; i < sacl_pkg::HALF; i++) begin
        cand[i].en <= 1'b0;
      end
    end
    if (state == ST_FIN) begin
      outcome   <= fin_outcome;
      extra_hit <= (item.cmd == sacl_pkg::CMD_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      lvl          <= '0;
      row_written  <= '0;
      acc_cnt      <= '0;
      hit_cnt      <= '0;
      miss_count   <= '0;
      evict_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_FIN);
      if (state == ST_LOOK) begin
        lvl <= '0;
      end else if (state == ST_TREE) begin
        lvl <= lvl + 1'b1;
      end
      if (state == ST_FIN) begin
        acc_cnt <= acc_cnt_new;
        hit_cnt <= sacl_pkg::sat_add(hit_cnt, hit_inc);
        if (cmd_ok && !hit_any) begin
          miss_count <= sacl_pkg::sat_add(miss_count, 2'd1);
          if (!empty_any) begin
            evict_cnt <= sacl_pkg::sat_add(evict_cnt, 2'd1);
          end
        end
      end
      if (wr_en) begin
        row_written[item.set] <= 1'b1;
      end
    end
  end

  assign hit_total      = hit_cnt;
  assign miss_total     = miss_count;
  assign eviction_total = evict_cnt;

  a_result_after_fin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_FIN)
    else $error("result strobe without a finishing step");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> hit_cnt >= $past(hit_cnt))
    else $error("hit total went down");

  a_evict_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid && (outcome == sacl_pkg::OUT_EVICT) |->
      (evict_cnt != $past(evict_cnt)) || (evict_cnt == {sacl_pkg::CNT_W{1'b1}}))
    else $error("eviction reported but not counted");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_LOOK)
    else $error("accepted access did not start a lookup");

endmodule

`default_nettype wire

/* sv/set_assoc_cache_lru_tracker_top.sv */
// Top level of the set-associative cache tag store with LRU replacement.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// An access (command, address) is a transaction taken at a rising edge with
// start high and busy low. The front end splits the address into set and tag
// using the configured offset and set bit counts and pushes it into a
// two-entry queue; busy is high only while that queue is full.
// The back end takes one access at a time through its set row memory: read
// the row, compare tags and find the first empty way while the first level
// of the LRU search runs, finish the LRU search one tree level per cycle,
// then write the updated row and the totals. It takes no new access until
// it has written back the last one; this is set by the read, search and
// write-back of the single row port. An access into an idle block passes
// through the queue and the lookup, tree and finish states, and its result
// is registered from the finish state.
// Each result is a one-cycle strobe on result_valid with outcome, extra_hit
// and the running totals; the receiver cannot stall, so nothing is held.
// Configuration registers are written through cfg_valid/cfg_ready (always
// ready) and must only change while no access is in flight.
// Reset empties the cache at once through per-set written flags, clears the
// counters and loads the default configuration; no clearing pass is needed.

module set_assoc_cache_lru_tracker_top (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire  [sacl_pkg::CMD_W-1:0]         command,
  input  wire  [sacl_pkg::ADDRESS_W-1:0]     address,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               result_valid,
  output logic [sacl_pkg::OUTCOME_W-1:0]     outcome,
  output logic                               extra_hit,
  output logic [sacl_pkg::CNT_W-1:0]         hit_total,
  output logic [sacl_pkg::CNT_W-1:0]         miss_total,
  output logic [sacl_pkg::CNT_W-1:0]         eviction_total
);

  sacl_pkg::acc_item_t dec_item;
  sacl_pkg::acc_item_t head;
  logic                head_valid;
  logic                pop;
  logic                full;
  logic                push;

  // An access is accepted whenever the queue has room.
  assign busy = full;
  assign push = start && !full;

  sacl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .address   (address),
    .item      (dec_item)
  );

  sacl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (dec_item),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (full)
  );

  sacl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .result_valid   (result_valid),
    .outcome        (outcome),
    .extra_hit      (extra_hit),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench of the set-associative cache tag store with LRU replacement.
`timescale 1ns / 1ps

module tb;
  import sacl_pkg::*;

  // The command value that names no access; it only advances the access count.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int LINES = NUM_SETS * MAX_WAYS;
  localparam int MAX_GAP = 13;

  // Fields of one result transaction, in port order.
  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 extra_hit;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     eviction_total;
  } cache_result_t;

  // The scoreboard keeps its own copy of the tag store, the stamps and the
  // totals. Every accepted access is replayed on that copy and the result it
  // must produce is queued; results leave the block in access order.
  class cache_scoreboard;
    bit               occupied [LINES];
    logic [63:0]      line_tags [LINES];
    logic [63:0]      last_use [LINES];
    logic [63:0]      access_count;
    logic [CNT_W-1:0] hits, misses, evictions;
    logic [SBITS_W-1:0] set_bits_reg;
    logic [OFFS_W-1:0]  offset_bits_reg;
    logic [WCFG_W-1:0]  ways_reg;
    cache_result_t    awaited [$];
    int               errors;

    function new();
      for (int i = 0; i < LINES; i++) begin
        occupied[i] = 1'b0;
        line_tags[i] = '0;
        last_use[i] = '0;
      end
      access_count = '0;
      hits = '0;
      misses = '0;
      evictions = '0;
      set_bits_reg = RST_SET_BITS;
      offset_bits_reg = RST_OFFSET_BITS;
      ways_reg = RST_WAYS;
      errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SET_BITS: set_bits_reg = data[SBITS_W-1:0];
        CFG_OFFSET_BITS: offset_bits_reg = data[OFFS_W-1:0];
        CFG_WAYS: ways_reg = data[WCFG_W-1:0];
        default: ;
      endcase
    endfunction

    // Totals hold at all ones instead of wrapping.
    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] cnt);
      return (cnt == '1) ? cnt : cnt + 1'b1;
    endfunction

    function void note_access(logic [CMD_W-1:0] cmd, logic [63:0] addr);
      int unsigned   sbits, nways, base;
      logic [63:0]   set_sel, tag_val;
      int            hit_way, empty_way, lru_way, victim;
      cache_result_t res;
      sbits = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
      nways = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
      set_sel = (addr >> offset_bits_reg) & ((64'd1 << sbits) - 64'd1);
      tag_val = addr >> (sbits + offset_bits_reg);
      base = 32'(set_sel * MAX_WAYS);
      hit_way = -1;
      empty_way = -1;
      lru_way = 0;
      res = '0;
      access_count = access_count + 1'b1;
      if (cmd != CMD_NONE) begin
        // Ways outside the configured count are left alone, contents and all.
        for (int w = 0; w < nways; w++) begin
          if (hit_way < 0 && occupied[base + w] && line_tags[base + w] == tag_val) begin
            hit_way = w;
          end
          if (empty_way < 0 && !occupied[base + w]) begin
            empty_way = w;
          end
          if (last_use[base + w] < last_use[base + lru_way]) begin
            lru_way = w;
          end
        end
        if (hit_way >= 0) begin
          last_use[base + hit_way] = access_count;
          hits = bump(hits);
          res.outcome = OUT_HIT;
        end else begin
          misses = bump(misses);
          if (empty_way >= 0) begin
            victim = base + empty_way;
            res.outcome = OUT_FILL;
          end else begin
            victim = base + lru_way;
            evictions = bump(evictions);
            res.outcome = OUT_EVICT;
          end
          occupied[victim] = 1'b1;
          line_tags[victim] = tag_val;
          last_use[victim] = access_count;
        end
        // The store half of a modify always hits the line just touched.
        if (cmd == CMD_MODIFY) begin
          res.extra_hit = 1'b1;
          hits = bump(hits);
        end
      end
      res.hit_total = hits;
      res.miss_total = misses;
      res.eviction_total = evictions;
      awaited.push_back(res);
    endfunction

    function void report(string field, logic [63:0] exp_val, logic [63:0] got_val);
      if (exp_val !== got_val) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                 got_val);
        errors++;
      end
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t exp_res;
      if (awaited.size() == 0) begin
        $display("%0t ns: result with no access waiting, actual outcome %0d hits %0d",
                 $time, got.outcome, got.hit_total);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      report("outcome", 64'(exp_res.outcome), 64'(got.outcome));
      report("extra_hit", 64'(exp_res.extra_hit), 64'(got.extra_hit));
      report("hit_total", 64'(exp_res.hit_total), 64'(got.hit_total));
      report("miss_total", 64'(exp_res.miss_total), 64'(got.miss_total));
      report("eviction_total", 64'(exp_res.eviction_total), 64'(got.eviction_total));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      command;
  logic [ADDRESS_W-1:0]  address;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  result_valid;
  logic [OUTCOME_W-1:0]  outcome;
  logic                  extra_hit;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      eviction_total;

  cache_scoreboard sb = new();

  // The geometry in force, already clamped, so that addresses can be built
  // to land on chosen sets and tags.
  int unsigned eff_sbits;
  int unsigned eff_offs;
  int unsigned eff_ways;
  // While set, the sender issues back-to-back transactions with no gaps.
  bit no_idle;

  set_assoc_cache_lru_tracker_top uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .address        (address),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .outcome        (outcome),
    .extra_hit      (extra_hit),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Results are strobes the testbench cannot stall, so every cycle with
  // result_valid high is one result transaction. Outputs are sampled at the
  // edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      sb.check_result({outcome, extra_hit, hit_total, miss_total, eviction_total});
    end
  end

  // Issues one access. The sender may first idle for a random number of
  // cycles; start stays high from the previous transaction when there is no
  // gap, so it is never lowered and raised within the same edge. The access
  // counts as accepted at the edge where busy was seen low.
  task automatic send_access(logic [CMD_W-1:0] cmd, logic [63:0] addr);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    address <= addr;
    do @(posedge clk); while (busy);
    sb.note_access(cmd, addr);
  endtask

  // Lets every outstanding result arrive, then waits on so that the back
  // end is surely idle before the configuration changes.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all three registers in consecutive transactions on the
  // configuration channel. The raw bytes may carry bits above each
  // register's width; the block keeps only the low bits.
  task automatic apply_config(logic [CFG_DATA_W-1:0] sbits_raw, logic [CFG_DATA_W-1:0] offs_raw,
                              logic [CFG_DATA_W-1:0] ways_raw);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{CFG_SET_BITS, CFG_OFFSET_BITS, CFG_WAYS};
    val = '{sbits_raw, offs_raw, ways_raw};
    drain();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    eff_sbits = (sbits_raw[SBITS_W-1:0] > MAX_SET_BITS) ? MAX_SET_BITS : sbits_raw[SBITS_W-1:0];
    eff_offs = offs_raw[OFFS_W-1:0];
    eff_ways = (ways_raw[WCFG_W-1:0] == 0) ? 1 :
               (ways_raw[WCFG_W-1:0] > MAX_WAYS) ? MAX_WAYS : ways_raw[WCFG_W-1:0];
  endtask

  // A random configuration: mostly small block offsets, sometimes very large
  // ones, and at times junk in the unused upper bits of each written byte.
  task automatic random_config();
    logic [CFG_DATA_W-1:0] s, o, w;
    s = 8'($urandom_range(0, 7));
    o = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(17, 31)) : 8'($urandom_range(0, 8));
    w = 8'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 1) begin
      s[7:3] = 5'($urandom);
      o[7:5] = 3'($urandom);
      w[7:4] = 4'($urandom);
    end
    apply_config(s, o, w);
  endtask

  // Random accesses aimed at a few sets and a pool of tags slightly larger
  // than the number of ways, so hits, fills and evictions all happen often.
  // One access in eight uses a fully random address as noise.
  task automatic random_phase(int count);
    logic [63:0]      tag_pool [16];
    logic [63:0]      set_pool [3];
    logic [63:0]      addr;
    logic [CMD_W-1:0] cmd;
    int unsigned      npool, pick;
    npool = eff_ways + $urandom_range(1, 4);
    for (int i = 0; i < npool; i++) begin
      tag_pool[i] = ($urandom_range(0, 1) == 1) ? 64'($urandom_range(0, 15)) :
                    {$urandom, $urandom};
    end
    for (int i = 0; i < 3; i++) begin
      set_pool[i] = 64'($urandom_range(0, (1 << eff_sbits) - 1));
    end
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        addr = {$urandom, $urandom};
      end else begin
        addr = (tag_pool[$urandom_range(0, npool - 1)] << (eff_sbits + eff_offs)) |
               (set_pool[$urandom_range(0, 2)] << eff_offs) |
               ({$urandom, $urandom} & ((64'd1 << eff_offs) - 64'd1));
      end
      pick = $urandom_range(0, 15);
      cmd = (pick == 0) ? CMD_NONE : (pick < 6) ? CMD_LOAD :
            (pick < 11) ? CMD_STORE : CMD_MODIFY;
      send_access(cmd, addr);
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_LOAD;
    address <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SET_BITS;
    cfg_data <= '0;
    no_idle = 1'b0;
    eff_sbits = RST_SET_BITS;
    eff_offs = RST_OFFSET_BITS;
    eff_ways = RST_WAYS;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Default geometry after reset: one set, 16-byte lines, a single way.
    // Fill, hit within the same line, evictions, the unused command and the
    // all-zero and all-one addresses.
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_STORE, 64'hF);
    send_access(CMD_MODIFY, 64'h10);
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_NONE, 64'h0);
    send_access(CMD_LOAD, '1);
    send_access(CMD_MODIFY, '1);
    send_access(CMD_STORE, 64'h8000_0000_0000_0000);

    // Set bit count above the maximum, the largest block offset and a way
    // count above the maximum: seven fills beside the line kept from the
    // default geometry, then the oldest lines go, then a re-touched line hits.
    apply_config(8'd7, 8'd31, 8'd15);
    for (int t = 0; t < 9; t++) begin
      send_access(CMD_LOAD, 64'(t) << 37);
    end
    send_access(CMD_MODIFY, 64'd2 << 37);
    send_access(CMD_LOAD, 64'd0);

    // No set bits, no offset and a way count of zero, which acts as one way.
    apply_config(8'd0, 8'd0, 8'd0);
    send_access(CMD_LOAD, 64'd1);
    send_access(CMD_STORE, 64'd1);
    send_access(CMD_MODIFY, 64'd2);
    send_access(CMD_NONE, '1);

    // Widening again brings back the lines hidden by the narrow setting.
    apply_config(8'd0, 8'd0, 8'd8);
    send_access(CMD_LOAD, 64'd1);
    send_access(CMD_LOAD, 64'd2);

    // Random phases, each under a new geometry. The stored lines survive
    // every change, so narrowing and widening keep exercising hidden ways.
    for (int p = 0; p < 10; p++) begin
      random_config();
      random_phase(200);
    end

    drain();
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hang: the slowest correct run is well under a fifth of
  // this.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
